// ----- rtl/ttbc_pkg.sv -----
`default_nettype none

package ttbc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_IN_BAR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD       = 3'd4;

    localparam logic [4:0]  RST_BEATS_IN_BAR = 5'd4;
    localparam logic [7:0]  RST_PULSE_TICKS  = 8'd100;
    localparam logic [11:0] RST_TAP_WINDOW   = 12'd2000;
    localparam logic [11:0] RST_MIN_PERIOD   = 12'd240;
    localparam logic [11:0] RST_MAX_PERIOD   = 12'd1500;
    localparam logic [15:0] RST_BEAT_PERIOD  = 16'd500;

    // stream payload
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    localparam int          TAP_BIT    = 4;
    localparam logic [4:0]  MOD_MASK   = 5'h07;
    localparam logic [7:0]  TAPS_MAX   = 8'hFF;
    localparam logic [7:0]  RAMP_FULL  = 8'hFF;
    localparam logic [17:0] STEP_FINE  = 18'sd1;
    localparam logic [17:0] STEP_COARSE = 18'sd10;

    // shared divider: numerator below divisor * 2**DIV_Q_W
    localparam int DIV_NUM_W = 29;
    localparam int DIV_DEN_W = 21;
    localparam int DIV_Q_W   = 16;
    localparam int BAR_LEN_W = 21;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_TAP,
        OP_TAP_WB,
        OP_ENC,
        OP_BEAT,
        OP_RAMP_SUB,
        OP_RAMP_CHK,
        OP_RAMP_WB,
        OP_OUT
    } ttbc_op_t;

    typedef struct packed {
        logic tap_div_req;
        logic ramp_div_req;
        logic div_done;
    } ttbc_status_t;

endpackage

`default_nettype wire

// ----- rtl/tap_tempo_beat_clock.sv -----
// Each request runs through the capture, tap, encoder, beat, ramp subtract, ramp check and output states;
//   a tap or a ramp divide adds 16 shift-subtract steps on the shared divider and a write-back.
// A new request is taken only in the idle state, after the previous one has passed the output state.
// The next request is taken while the previous result waits in the output register;
//   a stalled result holds the following one in its last state.
// Reset: aresetn synchronous, active low; configuration returns to its defaults,
//   period to 500 ticks, counters and the ramp base to zero.
`default_nettype none

module tap_tempo_beat_clock
    import ttbc_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [S_DATA_W-1:0]    s_tdata,   // pressed_buttons[4:0], encoder_bits[6:5]
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // beat_out[0], bar_out[1], tapping_led[2],
                                             // ramp_level[10:3], period_now[26:11]
    input  wire                   cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   cfg_addr,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

    ttbc_op_t     op;
    ttbc_status_t status;

    ttbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .op       (op)
    );

    ttbc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// ----- rtl/ttbc_div.sv -----
`default_nettype none

module ttbc_div
    import ttbc_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  wire [DIV_NUM_W-1:0]  num,
    input  wire [DIV_DEN_W-1:0]  den,
    output logic [DIV_Q_W-1:0]   quot,
    output logic                 done
);

    localparam int CNT_W = $clog2(DIV_Q_W);
    localparam int PAD_W = DIV_DEN_W - (DIV_NUM_W - DIV_Q_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   work_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    logic [DIV_DEN_W:0]   diff;

    always_comb begin
        trial = {rem_reg, work_reg[DIV_Q_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_Q_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // shift quotient bits in where numerator bits leave
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {{PAD_W{1'b0}}, num[DIV_NUM_W-1:DIV_Q_W]};
            work_reg <= num[DIV_Q_W-1:0];
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            work_reg <= {work_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign quot = work_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/ttbc_datapath.sv -----
`default_nettype none

module ttbc_datapath
    import ttbc_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire ttbc_op_t         op,
    output ttbc_status_t          status,
    input  wire [S_DATA_W-1:0]    s_tdata,
    output logic [M_DATA_W-1:0]   m_tdata,
    input  wire                   cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   cfg_addr,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

    // configuration
    logic [4:0]  bib_reg;
    logic [7:0]  pulse_reg;
    logic [11:0] window_reg;
    logic [11:0] minp_reg;
    logic [11:0] maxp_reg;

    // tick state
    logic [4:0]           btn_reg;
    logic [1:0]           enc_reg;
    logic [31:0]          tick_reg;
    logic [15:0]          period_reg;
    logic [15:0]          wait_reg;
    logic [7:0]           index_reg;
    logic [7:0]           beat_left_reg;
    logic [7:0]           bar_left_reg;
    logic [11:0]          tapping_reg;
    logic [7:0]           taps_reg;
    logic [15:0]          tap_origin_reg;
    logic [31:0]          bar_origin_reg;
    logic [BAR_LEN_W-1:0] bar_len_reg;
    logic [1:0]           prev_enc_reg;
    logic [4:0]           prev_btn_reg;

    // per-tick results
    logic [31:0]         elapsed_reg;
    logic                beat_flag_reg;
    logic                bar_flag_reg;
    logic                led_flag_reg;
    logic [7:0]          ramp_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                 btn_changed;
    logic                 tap_press;
    logic                 tap_div_req;
    logic [7:0]           taps_inc;
    logic [15:0]          span;
    logic signed [17:0]   enc_p;
    logic signed [17:0]   enc_step;
    logic                 beat_fire;
    logic [7:0]           index_inc;
    logic                 bar_fire;
    logic [BAR_LEN_W-1:0] bar_len_new;
    logic [7:0]           bar_left_src;
    logic                 elapsed_past;
    logic                 ramp_div_req;
    logic [DIV_NUM_W-1:0] ramp_num;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_Q_W-1:0]   div_quot;
    logic                 div_done;

    always_comb begin
        btn_changed = btn_reg != prev_btn_reg;
        tap_press   = btn_changed && btn_reg[TAP_BIT];
        tap_div_req = tap_press && (tapping_reg != '0);
        taps_inc    = (taps_reg != TAPS_MAX) ? taps_reg + 8'd1 : taps_reg;
        span        = tick_reg[15:0] - tap_origin_reg;

        // encoder step, then clamp low, then high
        enc_step = ((btn_reg & MOD_MASK) != '0) ? STEP_COARSE : STEP_FINE;
        enc_p    = $signed({2'b00, period_reg});
        if (enc_reg[0] && !prev_enc_reg[0]) begin
            enc_p = enc_reg[1] ? enc_p - enc_step : enc_p + enc_step;
        end
        if (enc_p < $signed({6'd0, minp_reg})) enc_p = $signed({6'd0, minp_reg});
        if (enc_p > $signed({6'd0, maxp_reg})) enc_p = $signed({6'd0, maxp_reg});

        beat_fire    = wait_reg == '0;
        index_inc    = index_reg + 8'd1;
        bar_fire     = beat_fire && (index_inc >= {3'd0, bib_reg});
        bar_len_new  = bib_reg * period_reg;
        bar_left_src = bar_fire ? pulse_reg : bar_left_reg;

        elapsed_past = (elapsed_reg[31:BAR_LEN_W] != '0)
                    || (elapsed_reg[BAR_LEN_W-1:0] >= bar_len_reg);
        ramp_div_req = (bar_len_reg != '0) && !elapsed_past;
        // elapsed * 255
        ramp_num = {elapsed_reg[BAR_LEN_W-1:0], 8'd0}
                 - {8'd0, elapsed_reg[BAR_LEN_W-1:0]};

        div_start = ((op == OP_TAP) && tap_div_req)
                 || ((op == OP_RAMP_CHK) && ramp_div_req);
        if (op == OP_TAP) begin
            div_num = {{(DIV_NUM_W-16){1'b0}}, span};
            div_den = {{(DIV_DEN_W-8){1'b0}}, taps_inc};
        end else begin
            div_num = ramp_num;
            div_den = bar_len_reg;
        end
    end

    ttbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bib_reg    <= RST_BEATS_IN_BAR;
            pulse_reg  <= RST_PULSE_TICKS;
            window_reg <= RST_TAP_WINDOW;
            minp_reg   <= RST_MIN_PERIOD;
            maxp_reg   <= RST_MAX_PERIOD;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_BEATS_IN_BAR:     bib_reg    <= cfg_wdata[4:0];
                CFG_PULSE_TICKS:      pulse_reg  <= cfg_wdata[7:0];
                CFG_TAP_WINDOW_TICKS: window_reg <= cfg_wdata;
                CFG_MIN_PERIOD:       minp_reg   <= cfg_wdata;
                CFG_MAX_PERIOD:       maxp_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btn_reg        <= '0;
            enc_reg        <= '0;
            tick_reg       <= '0;
            period_reg     <= RST_BEAT_PERIOD;
            wait_reg       <= '0;
            index_reg      <= '0;
            beat_left_reg  <= '0;
            bar_left_reg   <= '0;
            tapping_reg    <= '0;
            taps_reg       <= '0;
            tap_origin_reg <= '0;
            bar_origin_reg <= '0;
            bar_len_reg    <= '0;
            prev_enc_reg   <= '0;
            prev_btn_reg   <= '0;
        end else begin
            unique case (op)
                OP_CAPTURE: begin
                    btn_reg  <= s_tdata[4:0];
                    enc_reg  <= s_tdata[6:5];
                    tick_reg <= tick_reg + 32'd1;
                end
                OP_TAP: begin
                    if (btn_changed) begin
                        prev_btn_reg <= btn_reg;
                    end
                    if (tap_press) begin
                        if (tapping_reg != '0) begin
                            taps_reg <= taps_inc;
                        end else begin
                            tap_origin_reg <= tick_reg[15:0];
                            taps_reg       <= '0;
                            index_reg      <= {3'd0, bib_reg};
                        end
                        // force a beat and reopen the window
                        wait_reg    <= '0;
                        tapping_reg <= window_reg;
                    end
                end
                OP_TAP_WB: begin
                    period_reg <= div_quot;
                end
                OP_ENC: begin
                    if (enc_reg != prev_enc_reg) begin
                        period_reg   <= enc_p[15:0];
                        prev_enc_reg <= enc_reg;
                    end
                end
                OP_BEAT: begin
                    if (beat_fire) begin
                        beat_left_reg <= pulse_reg;
                        wait_reg      <= period_reg - 16'd1;
                        index_reg     <= bar_fire ? 8'd0 : index_inc;
                    end else begin
                        wait_reg <= wait_reg - 16'd1;
                        if (beat_left_reg != '0) beat_left_reg <= beat_left_reg - 8'd1;
                    end
                    if (bar_fire) begin
                        bar_origin_reg <= tick_reg;
                        bar_len_reg    <= bar_len_new;
                    end
                    bar_left_reg <= (bar_left_src != '0) ? bar_left_src - 8'd1 : bar_left_src;
                    if (tapping_reg != '0) tapping_reg <= tapping_reg - 12'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_BEAT: begin
                beat_flag_reg <= beat_fire || (beat_left_reg != '0);
                bar_flag_reg  <= bar_left_src != '0;
                led_flag_reg  <= tapping_reg != '0;
            end
            OP_RAMP_SUB: begin
                elapsed_reg <= tick_reg - bar_origin_reg;
            end
            OP_RAMP_CHK: begin
                // hold full before the first bar, clamp at zero past its end
                ramp_reg <= (bar_len_reg == '0) ? RAMP_FULL : 8'd0;
            end
            OP_RAMP_WB: begin
                ramp_reg <= RAMP_FULL - div_quot[7:0];
            end
            OP_OUT: begin
                out_data_reg <= {5'd0, period_reg, ramp_reg,
                                 led_flag_reg, bar_flag_reg, beat_flag_reg};
            end
            default: ;
        endcase
    end

    assign status.tap_div_req  = tap_div_req;
    assign status.ramp_div_req = ramp_div_req;
    assign status.div_done     = div_done;
    assign m_tdata             = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ttbc_ctrl.sv -----
`default_nettype none

module ttbc_ctrl
    import ttbc_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire                m_tready,
    input  wire ttbc_status_t  status,
    output ttbc_op_t           op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAP,
        ST_TAP_DIV,
        ST_TAP_WB,
        ST_ENC,
        ST_BEAT,
        ST_RAMP_SUB,
        ST_RAMP_CHK,
        ST_RAMP_DIV,
        ST_RAMP_WB,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        op            = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_CAPTURE;
                    state_next = ST_TAP;
                end
            end
            ST_TAP: begin
                op         = OP_TAP;
                state_next = status.tap_div_req ? ST_TAP_DIV : ST_ENC;
            end
            ST_TAP_DIV: begin
                if (status.div_done) state_next = ST_TAP_WB;
            end
            ST_TAP_WB: begin
                op         = OP_TAP_WB;
                state_next = ST_ENC;
            end
            ST_ENC: begin
                op         = OP_ENC;
                state_next = ST_BEAT;
            end
            ST_BEAT: begin
                op         = OP_BEAT;
                state_next = ST_RAMP_SUB;
            end
            ST_RAMP_SUB: begin
                op         = OP_RAMP_SUB;
                state_next = ST_RAMP_CHK;
            end
            ST_RAMP_CHK: begin
                op         = OP_RAMP_CHK;
                state_next = status.ramp_div_req ? ST_RAMP_DIV : ST_OUT;
            end
            ST_RAMP_DIV: begin
                if (status.div_done) state_next = ST_RAMP_WB;
            end
            ST_RAMP_WB: begin
                op         = OP_RAMP_WB;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    op            = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // no request is taken while reset is held
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- rtl/ttbc_checker.sv -----
`default_nettype none

module ttbc_checker
    import ttbc_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire [M_DATA_W-1:0]    m_tdata
);

    logic [1:0] pending_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // requests taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + {1'b0, s_acc} - {1'b0, m_acc};
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result without a pending request");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> pending_reg != 2'd2)
        else $error("request taken with two results outstanding");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("outstanding count out of range");

endmodule

bind tap_tempo_beat_clock ttbc_checker u_ttbc_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench
    import ttbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0] buttons;
        logic [1:0] enc;
    } tick_in_t;

    typedef struct packed {
        logic        beat;
        logic        bar;
        logic        led;
        logic [7:0]  ramp;
        logic [15:0] period;
    } tick_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;    // pressed_buttons[4:0], encoder_bits[6:5]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // beat_out[0], bar_out[1], tapping_led[2],
                                            // ramp_level[10:3], period_now[26:11]
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    tap_tempo_beat_clock i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // register mirror
    logic [4:0]  cfg_beats;
    logic [7:0]  cfg_pulse;
    logic [11:0] cfg_window;
    logic [11:0] cfg_min;
    logic [11:0] cfg_max;

    // beat clock state
    logic [31:0] ticks;
    logic [15:0] period_ticks;
    logic [15:0] wait_left;
    logic [7:0]  beat_no;
    logic [7:0]  beat_hold;
    logic [7:0]  bar_hold;
    logic [11:0] window_left;
    logic [7:0]  tap_total;
    logic [15:0] tap_start;
    logic [31:0] bar_start;
    logic [31:0] bar_span;
    logic [1:0]  last_enc;
    logic [4:0]  btn_before;

    tick_in_t  pending_ticks[$];
    tick_out_t clock_predictions[$];
    tick_in_t  next_tick;
    int        ticks_open = 0;
    int        errors = 0;
    int        in_wait = 0;
    int        out_stall = 0;
    logic      in_calm = 1'b0;
    logic      out_calm = 1'b0;

    task automatic clear_clock();
        cfg_beats    = RST_BEATS_IN_BAR;
        cfg_pulse    = RST_PULSE_TICKS;
        cfg_window   = RST_TAP_WINDOW;
        cfg_min      = RST_MIN_PERIOD;
        cfg_max      = RST_MAX_PERIOD;
        ticks        = '0;
        period_ticks = RST_BEAT_PERIOD;
        wait_left    = '0;
        beat_no      = '0;
        beat_hold    = '0;
        bar_hold     = '0;
        window_left  = '0;
        tap_total    = '0;
        tap_start    = '0;
        bar_start    = '0;
        bar_span     = '0;
        last_enc     = '0;
        btn_before   = '0;
    endtask

    function automatic tick_out_t advance_clock(input logic [4:0] buttons,
                                                input logic [1:0] enc);
        tick_out_t   res;
        logic [15:0] span;
        int          next_period;
        int          step;
        logic [63:0] frac;
        res = '0;
        ticks = ticks + 1;

        if (buttons != btn_before) begin
            btn_before = buttons;
            if (buttons[TAP_BIT]) begin
                if (window_left != 0) begin
                    span = ticks[15:0] - tap_start;
                    if (tap_total != TAPS_MAX) tap_total = tap_total + 8'd1;
                    period_ticks = span / tap_total;
                end else begin
                    // first tap of a window lines the next beat up as a bar
                    tap_start = ticks[15:0];
                    tap_total = '0;
                    beat_no = {3'b000, cfg_beats};
                end
                wait_left = '0;
                window_left = cfg_window;
            end
        end

        if (enc != last_enc) begin
            next_period = int'(period_ticks);
            step = ((buttons & MOD_MASK) != '0) ? int'(STEP_COARSE) : int'(STEP_FINE);
            if (enc[0] && !last_enc[0])
                next_period = enc[1] ? next_period - step : next_period + step;
            // clamp on every phase change, the upper bound wins
            if (next_period < int'(cfg_min)) next_period = int'(cfg_min);
            if (next_period > int'(cfg_max)) next_period = int'(cfg_max);
            period_ticks = next_period[15:0];
            last_enc = enc;
        end

        if (beat_hold != 0) begin
            beat_hold = beat_hold - 8'd1;
            res.beat = 1'b1;
        end
        if (wait_left != 0) begin
            wait_left = wait_left - 16'd1;
        end else begin
            beat_no = beat_no + 8'd1;
            if (beat_no >= {3'b000, cfg_beats}) begin
                beat_no = '0;
                bar_hold = cfg_pulse;
                bar_start = ticks;
                bar_span = {27'b0, cfg_beats} * {16'b0, period_ticks};
            end
            res.beat = 1'b1;
            beat_hold = cfg_pulse;
            wait_left = period_ticks - 16'd1;
        end
        if (bar_hold != 0) begin
            bar_hold = bar_hold - 8'd1;
            res.bar = 1'b1;
        end
        if (window_left != 0) begin
            res.led = 1'b1;
            window_left = window_left - 12'd1;
        end

        if (bar_span == 0) begin
            res.ramp = RAMP_FULL;
        end else begin
            frac = ({32'b0, ticks - bar_start} * {56'b0, RAMP_FULL}) / {32'b0, bar_span};
            res.ramp = (frac >= {56'b0, RAMP_FULL}) ? 8'd0 : RAMP_FULL - frac[7:0];
        end
        res.period = period_ticks;
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] data);
        tick_out_t want;
        if (clock_predictions.size() == 0) begin
            $display("%0t: result with no tick pending, expected none, actual %h",
                     $time, data);
            errors++;
        end else begin
            want = clock_predictions.pop_front();
            ticks_open--;
            compare_field("beat_out", want.beat, data[0]);
            compare_field("bar_out", want.bar, data[1]);
            compare_field("tapping_led", want.led, data[2]);
            compare_field("ramp_level", want.ramp, data[10:3]);
            compare_field("period_now", want.period, data[26:11]);
        end
    endtask

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                clock_predictions.push_back(advance_clock(s_tdata[4:0], s_tdata[6:5]));
            end
            if (!s_tvalid || s_tready) begin
                if (in_wait > 0) begin
                    in_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    next_tick = pending_ticks.pop_front();
                    s_tdata <= {1'b0, next_tick.enc, next_tick.buttons};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
                    in_wait = in_calm ? 0 : $urandom_range(0, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
                out_stall = out_calm ? 0 : $urandom_range(0, 9);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_tick(input logic [4:0] buttons, input logic [1:0] enc);
        tick_in_t t;
        t.buttons = buttons;
        t.enc = enc;
        pending_ticks.push_back(t);
        ticks_open++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BEATS_IN_BAR:     cfg_beats = val[4:0];
            CFG_PULSE_TICKS:      cfg_pulse = val[7:0];
            CFG_TAP_WINDOW_TICKS: cfg_window = val[11:0];
            CFG_MIN_PERIOD:       cfg_min = val[11:0];
            CFG_MAX_PERIOD:       cfg_max = val[11:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input int beats, input int pulse, input int window,
                            input int lo, input int hi);
        write_reg(CFG_BEATS_IN_BAR, beats[CFG_DATA_W-1:0]);
        write_reg(CFG_PULSE_TICKS, pulse[CFG_DATA_W-1:0]);
        write_reg(CFG_TAP_WINDOW_TICKS, window[CFG_DATA_W-1:0]);
        write_reg(CFG_MIN_PERIOD, lo[CFG_DATA_W-1:0]);
        write_reg(CFG_MAX_PERIOD, hi[CFG_DATA_W-1:0]);
    endtask

    // hold until every tick has its result, then let the divider go quiet
    task automatic settle();
        while (ticks_open != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // tap presses with random spacing, a turning encoder, modifiers and noise
    task automatic queue_ticks(input int count, input int gap_max);
        int         until_tap;
        int         hold_left;
        int         spot;
        logic       forward;
        logic       lock;
        logic [2:0] mods;
        logic [1:0] enc;
        until_tap = $urandom_range(1, gap_max);
        hold_left = 0;
        spot = 0;
        forward = 1'b1;
        lock = 1'b0;
        mods = '0;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                add_tick(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
            end else begin
                if (hold_left > 0) begin
                    hold_left--;
                end else if (until_tap > 0) begin
                    until_tap--;
                end else begin
                    hold_left = $urandom_range(1, 3);
                    // now and then pause longer, which can close a short window
                    until_tap = ($urandom_range(0, 7) == 0) ?
                                $urandom_range(gap_max, 4 * gap_max + 50) :
                                $urandom_range(1, gap_max);
                end
                if ($urandom_range(0, 2) == 0) begin
                    if ($urandom_range(0, 9) == 0) forward = !forward;
                    spot = forward ? spot + 1 : spot + 3;
                end
                if ($urandom_range(0, 19) == 0)
                    mods = $urandom_range(0, 1) ? 3'b000 : 3'($urandom_range(1, 7));
                if ($urandom_range(0, 29) == 0) lock = !lock;
                case (spot % 4)
                    0: enc = 2'b00;
                    1: enc = 2'b01;
                    2: enc = 2'b11;
                    default: enc = 2'b10;
                endcase
                add_tick({hold_left > 0, lock, mods}, enc);
            end
        end
    endtask

    initial begin
        clear_clock();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: ramp full before the first bar, first tap forces a bar,
        // taps inside the window, modifier steps, lock alone, both encoder directions
        add_tick(5'h00, 2'b00);
        add_tick(5'h1F, 2'b11);
        add_tick(5'h0F, 2'b00);
        add_tick(5'h10, 2'b01);
        add_tick(5'h00, 2'b01);
        add_tick(5'h10, 2'b01);
        add_tick(5'h11, 2'b01);
        add_tick(5'h11, 2'b01);
        add_tick(5'h11, 2'b01);
        add_tick(5'h11, 2'b01);
        add_tick(5'h08, 2'b11);
        add_tick(5'h01, 2'b10);
        add_tick(5'h02, 2'b11);
        add_tick(5'h04, 2'b01);
        add_tick(5'h00, 2'b00);
        add_tick(5'h00, 2'b01);
        add_tick(5'h00, 2'b00);
        add_tick(5'h07, 2'b01);
        add_tick(5'h00, 2'b10);
        add_tick(5'h00, 2'b11);
        queue_ticks(180, 40);
        settle();

        set_regs(1, 1, 1, 1, 1);
        queue_ticks(180, 6);
        settle();

        // rapid taps past the tap count limit
        set_regs(16, 255, 4095, 4095, 4095);
        for (int k = 0; k < 270; k++) add_tick({4'b1000, k[0]}, 2'b00);
        queue_ticks(180, 30);
        settle();

        // zero beats per bar, zero pulse length, lower bound above upper bound
        set_regs(0, 0, 100, 20, 10);
        queue_ticks(180, 20);
        settle();

        set_regs(3, 5, 200, 8, 60);
        queue_ticks(180, 25);
        settle();

        set_regs($urandom_range(1, 16), $urandom_range(1, 255), $urandom_range(1, 4095),
                 $urandom_range(1, 100), $urandom_range(1, 4095));
        queue_ticks(180, 40);
        settle();

        set_regs(7, 20, 50, 2, 4095);
        queue_ticks(180, 60);
        settle();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/ttbc_pkg.sv
rtl/ttbc_div.sv
rtl/ttbc_datapath.sv
rtl/ttbc_ctrl.sv
rtl/tap_tempo_beat_clock.sv
rtl/ttbc_checker.sv
dv/testbench.sv
